### rtl/proximity_to_range_scan_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the proximity range scan block
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef PROXIMITY_TO_RANGE_SCAN_TOP_ASSERT_SVH
`define PROXIMITY_TO_RANGE_SCAN_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define PTS_ASSERT_IMPL(label, clk, rstn, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define PTS_ASSERT_NEXT(label, clk, rstn, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
    else $error(msg);

`endif

### rtl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types, constants and the lane tap table of the range scan block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pts_pkg;

  localparam int PTS_SAMPLE_BITS = 10;
  localparam int PTS_NUM_SENSORS = 8;
  localparam int PTS_NUM_SLOTS   = 27;
  localparam int PTS_SLOT_W      = 5;
  localparam int PTS_RANGE_W     = 16;
  localparam int PTS_INTEN_W     = 10;

  // Register map
  typedef enum logic [1:0] {
    PTS_REG_ENABLE      = 2'd0,
    PTS_REG_MIN_RANGE   = 2'd1,
    PTS_REG_MAX_RANGE   = 2'd2,
    PTS_REG_BODY_RADIUS = 2'd3
  } pts_reg_t;

  localparam logic                   PTS_RST_ENABLE = 1'b1;
  localparam logic [PTS_RANGE_W-1:0] PTS_RST_MIN    = 16'd328;
  localparam logic [PTS_RANGE_W-1:0] PTS_RST_MAX    = 16'd3277;
  localparam logic [PTS_RANGE_W-1:0] PTS_RST_RADIUS = 16'd1638;

  typedef struct packed {
    logic                   enable;
    logic [PTS_RANGE_W-1:0] range_lo;
    logic [PTS_RANGE_W-1:0] range_hi;
    logic [PTS_RANGE_W-1:0] body_radius;
  } pts_cfg_t;

  // Tags that travel with one result through the converter
  typedef struct packed {
    logic                  kind;
    logic [PTS_SLOT_W-1:0] slot;
    logic                  last;
  } pts_meta_t;

  // One lane: a*wa/den + b*wb/den (den 5 or 4), or sensor a taken as is
  typedef struct packed {
    logic [2:0] a;
    logic [2:0] wa;
    logic [2:0] b;
    logic [2:0] wb;
    logic       den5;
    logic       direct;
  } pts_tap_t;

  localparam pts_tap_t PTS_TAPS [PTS_NUM_SLOTS] = '{
    '{3'd0, 3'd1, 3'd0, 3'd0, 1'b0, 1'b1},
    '{3'd1, 3'd1, 3'd0, 3'd0, 1'b0, 1'b1},
    '{3'd2, 3'd1, 3'd0, 3'd0, 1'b0, 1'b1},
    '{3'd3, 3'd1, 3'd0, 3'd0, 1'b0, 1'b1},
    '{3'd4, 3'd1, 3'd0, 3'd0, 1'b0, 1'b1},
    '{3'd5, 3'd1, 3'd0, 3'd0, 1'b0, 1'b1},
    '{3'd6, 3'd1, 3'd0, 3'd0, 1'b0, 1'b1},
    '{3'd7, 3'd1, 3'd0, 3'd0, 1'b0, 1'b1},
    '{3'd2, 3'd5, 3'd1, 3'd0, 1'b1, 1'b0},
    '{3'd2, 3'd4, 3'd1, 3'd1, 1'b1, 1'b0},
    '{3'd2, 3'd3, 3'd1, 3'd2, 1'b1, 1'b0},
    '{3'd2, 3'd2, 3'd1, 3'd3, 1'b1, 1'b0},
    '{3'd2, 3'd1, 3'd1, 3'd4, 1'b1, 1'b0},
    '{3'd1, 3'd4, 3'd0, 3'd0, 1'b0, 1'b0},
    '{3'd1, 3'd3, 3'd0, 3'd1, 1'b0, 1'b0},
    '{3'd1, 3'd2, 3'd0, 3'd2, 1'b0, 1'b0},
    '{3'd1, 3'd1, 3'd0, 3'd3, 1'b0, 1'b0},
    '{3'd0, 3'd4, 3'd7, 3'd0, 1'b0, 1'b0},
    '{3'd7, 3'd1, 3'd0, 3'd3, 1'b0, 1'b0},
    '{3'd7, 3'd2, 3'd0, 3'd2, 1'b0, 1'b0},
    '{3'd7, 3'd3, 3'd0, 3'd1, 1'b0, 1'b0},
    '{3'd7, 3'd5, 3'd6, 3'd0, 1'b1, 1'b0},
    '{3'd7, 3'd4, 3'd6, 3'd1, 1'b1, 1'b0},
    '{3'd7, 3'd3, 3'd6, 3'd2, 1'b1, 1'b0},
    '{3'd7, 3'd2, 3'd6, 3'd3, 1'b1, 1'b0},
    '{3'd7, 3'd1, 3'd6, 3'd4, 1'b1, 1'b0},
    '{3'd6, 3'd5, 3'd7, 3'd0, 1'b1, 1'b0}
  };

endpackage

`default_nettype wire

### rtl/pts_lane.sv
// ----------------------------------------------------------------------------
// pts_lane
// One lane: raw value of one sensor or one interpolated ray, per frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pts_lane
  import pts_pkg::*;
#(
  parameter int SAMPLE_BITS = PTS_SAMPLE_BITS,
  parameter int SLOT        = 0
) (
  input  wire logic                                          clk,
  input  wire logic                                          load,
  input  wire logic [PTS_NUM_SENSORS-1:0][SAMPLE_BITS-1:0]   samples,
  output logic      [SAMPLE_BITS-1:0]                        value_r
);

  localparam pts_tap_t TAP = PTS_TAPS[SLOT];
  localparam int XW = SAMPLE_BITS + 3;          // product of sample and weight
  localparam int K5 = XW + 3;                   // reciprocal shift for /5
  localparam longint unsigned M5 = ((64'd1 << K5) + 64'd4) / 64'd5;
  localparam int PW = XW + K5;

  logic [XW-1:0]          xa, xb;
  logic [PW-1:0]          pa, pb;
  logic [SAMPLE_BITS-1:0] fa, fb, value_nxt;

  // Weight each tap, then floor-divide by five or four
  always_comb begin
    xa = XW'(samples[TAP.a]) * XW'(TAP.wa);
    xb = XW'(samples[TAP.b]) * XW'(TAP.wb);
    pa = PW'(xa) * PW'(M5);
    pb = PW'(xb) * PW'(M5);
    if (TAP.den5) begin
      fa = SAMPLE_BITS'(pa >> K5);
      fb = SAMPLE_BITS'(pb >> K5);
    end else begin
      fa = SAMPLE_BITS'(xa >> 2);
      fb = SAMPLE_BITS'(xb >> 2);
    end
    value_nxt = TAP.direct ? samples[TAP.a] : fa + fb;
  end

  // Capture on the accepted beat
  always_ff @(posedge clk) begin
    if (load) begin
      value_r <= value_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/pts_conv.sv
// ----------------------------------------------------------------------------
// pts_conv
// Pipelined raw-to-range converter: bit-per-stage root search, linear segment,
// radius add and clamp. Takes one value per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pts_conv
  import pts_pkg::*;
#(
  parameter int SAMPLE_BITS = PTS_SAMPLE_BITS
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire pts_cfg_t                 cfg,
  input  wire logic                     iss_valid,
  input  wire pts_meta_t                iss_meta,
  input  wire logic [SAMPLE_BITS-1:0]   iss_value,
  output logic                          res_valid_r,
  output pts_meta_t                     res_meta_r,
  output logic [PTS_RANGE_W-1:0]        res_distance_r,
  output logic [PTS_INTEN_W-1:0]        res_intensity_r
);

  localparam int VX     = (SAMPLE_BITS > 13) ? SAMPLE_BITS : 13;
  localparam int ROOT_W = 21;
  localparam int NSTG   = ROOT_W;
  localparam logic [40:0] SQ_LIMIT   = 41'd1391569403904;  // (0.18*65536*100)^2
  localparam logic [21:0] RND_OFS    = 22'd32818;
  localparam logic [21:0] RECIP_100  = 22'd2684355;        // ceil(2^28/100)
  localparam logic [33:0] LIN_C      = 34'd4888197650;
  localparam logic [33:0] LIN_SLOPE  = 34'd786432;
  localparam logic [30:0] RECIP_LIN  = 31'd1125899907;     // ceil(2^44/15625)

  typedef struct packed {
    pts_meta_t              meta;
    logic                   zero;
    logic                   lin;
    logic                   sat;
    logic [12:0]            vlin;
    logic [PTS_INTEN_W-1:0] inten;
  } pipe_t;

  logic [VX-1:0] vx;
  pipe_t         ent_nxt;
  logic [9:0]    vs_nxt;

  logic              vld_r  [NSTG+1];
  pipe_t             pipe_r [NSTG+1];
  logic [ROOT_W-1:0] root_r [NSTG+1];
  logic [40:0]       sq_r   [NSTG+1];
  logic [30:0]       vr_r   [NSTG+1];
  logic [9:0]        vs_r   [NSTG+1];

  // Classify the value and pick the branch inputs
  always_comb begin
    vx            = VX'(iss_value);
    ent_nxt.meta  = iss_meta;
    ent_nxt.zero  = (vx == '0);
    ent_nxt.lin   = (vx > VX'(950));
    ent_nxt.sat   = (vx > VX'(6215));
    ent_nxt.vlin  = ent_nxt.sat ? 13'd6215 : vx[12:0];
    ent_nxt.inten = iss_meta.kind ? vx[9:0] : '0;
    vs_nxt        = ent_nxt.lin ? 10'd950 : vx[9:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= iss_valid;
    end
  end

  always_ff @(posedge clk) begin
    pipe_r[0] <= ent_nxt;
    vs_r[0]   <= vs_nxt;
    root_r[0] <= '0;
    sq_r[0]   <= '0;
    vr_r[0]   <= '0;
  end

  // Root search: largest r with v*r*r <= limit, one bit per stage
  for (genvar g = 0; g < NSTG; g++) begin : g_root
    localparam int B = NSTG - 1 - g;
    logic [53:0] trial;
    logic        fit;

    always_comb begin
      trial = 54'(sq_r[g]) + (54'(vr_r[g]) << (B + 1)) + (54'(vs_r[g]) << (2 * B));
      fit   = (trial <= 54'(SQ_LIMIT));
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else begin
        vld_r[g+1] <= vld_r[g];
      end
    end

    always_ff @(posedge clk) begin
      pipe_r[g+1] <= pipe_r[g];
      vs_r[g+1]   <= vs_r[g];
      if (fit) begin
        root_r[g+1] <= root_r[g] | (ROOT_W'(1) << B);
        sq_r[g+1]   <= trial[40:0];
        vr_r[g+1]   <= vr_r[g] + (31'(vs_r[g]) << B);
      end else begin
        root_r[g+1] <= root_r[g];
        sq_r[g+1]   <= sq_r[g];
        vr_r[g+1]   <= vr_r[g];
      end
    end
  end

  // Stage A: round-and-scale product, linear numerator
  logic        a_vld_r;
  pipe_t       a_pipe_r;
  logic [43:0] a_prod_r;
  logic [29:0] a_linm_r;
  logic [21:0] a_sum;
  logic [33:0] a_diff;

  always_comb begin
    a_sum  = 22'(root_r[NSTG]) + RND_OFS;
    a_diff = LIN_C - 34'(pipe_r[NSTG].vlin) * LIN_SLOPE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= vld_r[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    a_pipe_r <= pipe_r[NSTG];
    a_prod_r <= 44'(a_sum) * 44'(RECIP_100);
    a_linm_r <= a_diff[31:2];
  end

  // Stage B: finish divide by 100, linear reciprocal product
  logic        b_vld_r;
  pipe_t       b_pipe_r;
  logic [13:0] b_sqd_r;
  logic [60:0] b_linp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    b_pipe_r <= a_pipe_r;
    b_sqd_r  <= a_prod_r[41:28];
    b_linp_r <= 61'(a_linm_r) * 61'(RECIP_LIN);
  end

  // Stage C: select branch, add radius, clamp
  logic [16:0]        lin_q;
  logic signed [18:0] conv;
  logic [16:0]        rad, lo, hi;
  logic signed [19:0] d;
  logic [PTS_RANGE_W-1:0] dist_nxt;

  always_comb begin
    lin_q = b_linp_r[60:44];
    if (b_pipe_r.sat) begin
      conv = -19'sd65536;
    end else if (b_pipe_r.lin) begin
      conv = $signed({2'b00, lin_q}) - 19'sd65536;
    end else begin
      conv = $signed({5'b00000, b_sqd_r});
    end
    rad = b_pipe_r.meta.kind ? {1'b0, cfg.body_radius} : 17'd0;
    lo  = {1'b0, cfg.range_lo} + rad;
    hi  = {1'b0, cfg.range_hi} + rad;
    if (b_pipe_r.zero) begin
      d = $signed({3'b000, hi});
    end else begin
      d = 20'(conv) + $signed({3'b000, rad});
    end
    if (d > $signed({3'b000, hi})) begin
      d = $signed({3'b000, hi});
    end
    if (d < $signed({3'b000, lo})) begin
      d = $signed({3'b000, lo});
    end
    if (d < 20'sd0) begin
      d = 20'sd0;
    end
    if (d > 20'sd65535) begin
      d = 20'sd65535;
    end
    dist_nxt = d[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    res_meta_r      <= b_pipe_r.meta;
    res_distance_r  <= dist_nxt;
    res_intensity_r <= b_pipe_r.inten;
  end

endmodule

`default_nettype wire

### rtl/proximity_to_range_scan_top.sv
// ----------------------------------------------------------------------------
// proximity_to_range_scan_top
// The 27 results of an enabled frame follow one per cycle once it is
// accepted, sensors first, then rays, from the single converter pipeline
// that takes one lane per cycle. Busy stays high after accept until the
// sequencer reaches the last lane, when the next frame can be accepted.
// Results cannot be held off. Reset clears the sequencer and pipeline valids
// and restores the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module proximity_to_range_scan_top
  import pts_pkg::*;
#(
  parameter int SAMPLE_BITS = PTS_SAMPLE_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [SAMPLE_BITS-1:0] in_front,
  input  wire logic [SAMPLE_BITS-1:0] in_front_right,
  input  wire logic [SAMPLE_BITS-1:0] in_right,
  input  wire logic [SAMPLE_BITS-1:0] in_rear_right,
  input  wire logic [SAMPLE_BITS-1:0] in_rear,
  input  wire logic [SAMPLE_BITS-1:0] in_rear_left,
  input  wire logic [SAMPLE_BITS-1:0] in_left,
  input  wire logic [SAMPLE_BITS-1:0] in_front_left,
  output logic                        out_valid,
  output logic                        out_kind,
  output logic [PTS_SLOT_W-1:0]       out_slot,
  output logic [PTS_RANGE_W-1:0]      out_distance,
  output logic [PTS_INTEN_W-1:0]      out_intensity,
  output logic                        out_last,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [PTS_RANGE_W-1:0] cfg_data
);

  localparam logic [PTS_SLOT_W-1:0] LAST_IDX = PTS_SLOT_W'(PTS_NUM_SLOTS - 1);
  localparam logic [PTS_SLOT_W-1:0] NSENS    = PTS_SLOT_W'(PTS_NUM_SENSORS);

  pts_cfg_t cfg_r;
  logic     run_r, run_nxt;
  logic     en_r, en_nxt;
  logic [PTS_SLOT_W-1:0] idx_r, idx_nxt;
  logic     accept;

  logic [PTS_NUM_SENSORS-1:0][SAMPLE_BITS-1:0] samples;
  logic [SAMPLE_BITS-1:0] lane_v [PTS_NUM_SLOTS];

  logic                   iss_valid;
  pts_meta_t              iss_meta;
  logic [SAMPLE_BITS-1:0] iss_value;
  pts_meta_t              res_meta;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable      <= PTS_RST_ENABLE;
      cfg_r.range_lo    <= PTS_RST_MIN;
      cfg_r.range_hi    <= PTS_RST_MAX;
      cfg_r.body_radius <= PTS_RST_RADIUS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (pts_reg_t'(cfg_index))
        PTS_REG_ENABLE:      cfg_r.enable      <= cfg_data[0];
        PTS_REG_MIN_RANGE:   cfg_r.range_lo    <= cfg_data;
        PTS_REG_MAX_RANGE:   cfg_r.range_hi    <= cfg_data;
        PTS_REG_BODY_RADIUS: cfg_r.body_radius <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame sequencer: walk the 27 lanes, take the next beat on the last one
  assign busy   = run_r && (idx_r != LAST_IDX);
  assign accept = start && !busy;

  always_comb begin
    run_nxt = run_r;
    idx_nxt = idx_r;
    en_nxt  = en_r;
    if (accept) begin
      run_nxt = 1'b1;
      idx_nxt = '0;
      en_nxt  = cfg_r.enable;
    end else if (run_r) begin
      if (idx_r == LAST_IDX) begin
        run_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      idx_r <= '0;
      en_r  <= 1'b0;
    end else begin
      run_r <= run_nxt;
      idx_r <= idx_nxt;
      en_r  <= en_nxt;
    end
  end

  // Lanes: one per sensor range and per ray
  assign samples = {in_front_left, in_left, in_rear_left, in_rear,
                    in_rear_right, in_right, in_front_right, in_front};

  for (genvar g = 0; g < PTS_NUM_SLOTS; g++) begin : g_lane
    pts_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .SLOT        (g)
    ) u_lane (
      .clk     (clk),
      .load    (accept),
      .samples (samples),
      .value_r (lane_v[g])
    );
  end

  // Merge: pick one lane per cycle into the converter
  always_comb begin
    iss_valid     = run_r && en_r;
    iss_value     = lane_v[idx_r];
    iss_meta.kind = (idx_r >= NSENS);
    iss_meta.slot = iss_meta.kind ? idx_r - NSENS : idx_r;
    iss_meta.last = (idx_r == LAST_IDX);
  end

  pts_conv #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_conv (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .iss_valid       (iss_valid),
    .iss_meta        (iss_meta),
    .iss_value       (iss_value),
    .res_valid_r     (out_valid),
    .res_meta_r      (res_meta),
    .res_distance_r  (out_distance),
    .res_intensity_r (out_intensity)
  );

  assign out_kind = res_meta.kind;
  assign out_slot = res_meta.slot;
  assign out_last = res_meta.last;

endmodule

`default_nettype wire

### rtl/pts_chk.sv
// ----------------------------------------------------------------------------
// pts_chk
// Port-level checks of the range scan block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "proximity_to_range_scan_top_assert.svh"

module pts_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       out_valid,
  input wire logic       out_kind,
  input wire logic [4:0] out_slot,
  input wire logic [9:0] out_intensity,
  input wire logic       out_last
);

  // Last flag only on the final ray
  `PTS_ASSERT_IMPL(a_last_ray, clk, rst_n, out_valid && out_last, out_kind && out_slot == 5'd18, "last flag off the final ray")

  // Sensor beats carry no intensity and no last flag
  `PTS_ASSERT_IMPL(a_sensor_beat, clk, rst_n, out_valid && !out_kind, out_intensity == 10'd0 && !out_last && out_slot < 5'd8, "bad sensor beat")

  // Ray numbers stay in range
  `PTS_ASSERT_IMPL(a_ray_slot, clk, rst_n, out_valid && out_kind, out_slot < 5'd19, "ray slot out of range")

  // Busy is raised in the cycle after a frame is accepted
  `PTS_ASSERT_NEXT(a_busy_after_start, clk, rst_n, start && !busy, busy, "not busy after accept")

endmodule

bind proximity_to_range_scan_top pts_chk u_pts_chk (.*);

`default_nettype wire

### bench/scan_checker.sv
// ----------------------------------------------------------------------------
// scan_checker
// Watches the frame, register and result channels of the range scan block.
// It keeps its own copy of the registers and works out the 27 results of
// each frame accepted while enabled. Each result beat is then compared, in
// all its fields, with the oldest result still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scan_checker
  import pts_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   busy,
  input  logic [7:0][9:0]        frame,
  input  logic                   out_valid,
  input  logic                   out_kind,
  input  logic [PTS_SLOT_W-1:0]  out_slot,
  input  logic [PTS_RANGE_W-1:0] out_distance,
  input  logic [PTS_INTEN_W-1:0] out_intensity,
  input  logic                   out_last,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  pts_reg_t               cfg_index,
  input  logic [PTS_RANGE_W-1:0] cfg_data,
  output int                     fails,
  output int                     pending
);

  typedef struct packed {
    logic                   kind;
    logic [PTS_SLOT_W-1:0]  slot;
    logic [PTS_RANGE_W-1:0] distance;
    logic [PTS_INTEN_W-1:0] intensity;
    logic                   last;
  } scan_beat_t;

  scan_beat_t scan_q[$];

  logic                   en_r;
  logic [PTS_RANGE_W-1:0] min_r;
  logic [PTS_RANGE_W-1:0] max_r;
  logic [PTS_RANGE_W-1:0] radius_r;

  initial begin
    fails = 0;
    pending = 0;
  end

  // Bitwise integer square root
  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Raw reading (nonzero) to Q0.16 metres: root law, then linear above 950
  function automatic longint raw_to_q16(int unsigned v);
    longint unsigned q;
    longint n;
    if (v <= 950) begin
      q = isqrt(64'd1391569403904 / v);
      return longint'((q + 32818) / 100);
    end
    n = (193400 - 192 * longint'(v)) * 65536 + 500000;
    if (n >= 0) return n / 1000000;
    return -((-n + 999999) / 1000000);
  endfunction

  function automatic logic [15:0] clip(longint d, longint lo, longint hi);
    if (d > hi) d = hi;
    if (d < lo) d = lo;
    if (d < 0) d = 0;
    if (d > 65535) d = 65535;
    return d[15:0];
  endfunction

  // Interpolate ray i from the right, front and left sensors, each term floored
  function automatic int unsigned ray_level(int i, logic [7:0][9:0] s);
    int unsigned a, b, wa, wb, den;
    den = 4;
    case (i)
      0:  begin a = s[2]; wa = 5; b = s[1]; wb = 0; den = 5; end
      1:  begin a = s[2]; wa = 4; b = s[1]; wb = 1; den = 5; end
      2:  begin a = s[2]; wa = 3; b = s[1]; wb = 2; den = 5; end
      3:  begin a = s[2]; wa = 2; b = s[1]; wb = 3; den = 5; end
      4:  begin a = s[2]; wa = 1; b = s[1]; wb = 4; den = 5; end
      5:  begin a = s[1]; wa = 4; b = s[0]; wb = 0; end
      6:  begin a = s[1]; wa = 3; b = s[0]; wb = 1; end
      7:  begin a = s[1]; wa = 2; b = s[0]; wb = 2; end
      8:  begin a = s[1]; wa = 1; b = s[0]; wb = 3; end
      9:  begin a = s[0]; wa = 4; b = s[7]; wb = 0; end
      10: begin a = s[7]; wa = 1; b = s[0]; wb = 3; end
      11: begin a = s[7]; wa = 2; b = s[0]; wb = 2; end
      12: begin a = s[7]; wa = 3; b = s[0]; wb = 1; end
      13: begin a = s[7]; wa = 5; b = s[6]; wb = 0; den = 5; end
      14: begin a = s[7]; wa = 4; b = s[6]; wb = 1; den = 5; end
      15: begin a = s[7]; wa = 3; b = s[6]; wb = 2; den = 5; end
      16: begin a = s[7]; wa = 2; b = s[6]; wb = 3; den = 5; end
      17: begin a = s[7]; wa = 1; b = s[6]; wb = 4; den = 5; end
      default: begin a = s[6]; wa = 5; b = s[7]; wb = 0; den = 5; end
    endcase
    return (a * wa) / den + (b * wb) / den;
  endfunction

  // Queue the sensor beats, then the ray beats, of one frame while enabled
  task automatic predict_frame(logic [7:0][9:0] s);
    scan_beat_t e;
    longint d, lo, hi;
    int unsigned v;
    if (!en_r) return;
    for (int i = 0; i < 8; i++) begin
      d = (s[i] != 0) ? raw_to_q16(s[i]) : longint'(max_r);
      e = '{1'b0, i[4:0], clip(d, min_r, max_r), 10'd0, 1'b0};
      scan_q.push_back(e);
    end
    lo = longint'(min_r) + longint'(radius_r);
    hi = longint'(max_r) + longint'(radius_r);
    for (int i = 0; i < 19; i++) begin
      v = ray_level(i, s);
      d = (v != 0) ? raw_to_q16(v) + longint'(radius_r) : hi;
      e = '{1'b1, i[4:0], clip(d, lo, hi), v[9:0], i == 18};
      scan_q.push_back(e);
    end
  endtask

  always @(posedge clk) begin
    scan_beat_t e;
    if (!rst_n) begin
      en_r <= PTS_RST_ENABLE;
      min_r <= PTS_RST_MIN;
      max_r <= PTS_RST_MAX;
      radius_r <= PTS_RST_RADIUS;
    end else begin
      // Track register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          PTS_REG_ENABLE:    en_r <= cfg_data[0];
          PTS_REG_MIN_RANGE: min_r <= cfg_data;
          PTS_REG_MAX_RANGE: max_r <= cfg_data;
          default:           radius_r <= cfg_data;
        endcase
      end
      // Compare each result beat with the oldest expectation
      if (out_valid) begin
        if (scan_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected beat kind %0d slot %0d dist %0d inten %0d last %0d",
                   $time, out_kind, out_slot, out_distance, out_intensity, out_last);
        end else begin
          e = scan_q.pop_front();
          if (e != {out_kind, out_slot, out_distance, out_intensity, out_last}) begin
            fails++;
            $display("%0t: mismatch exp kind %0d slot %0d dist %0d inten %0d last %0d",
                     $time, e.kind, e.slot, e.distance, e.intensity, e.last);
            $display("%0t:          got kind %0d slot %0d dist %0d inten %0d last %0d",
                     $time, out_kind, out_slot, out_distance, out_intensity, out_last);
          end
        end
      end
      // Predict each accepted frame
      if (start && !busy) predict_frame(frame);
    end
    pending = scan_q.size();
  end

endmodule

### bench/tb_proximity_to_range_scan_top.sv
// ----------------------------------------------------------------------------
// tb_proximity_to_range_scan_top
// Drives frames of raw readings and register writes into the range scan
// block over several register settings and idle patterns; a checker beside
// the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_proximity_to_range_scan_top;
  import pts_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [7:0][9:0]        frame = '0;
  logic                   out_valid;
  logic                   out_kind;
  logic [PTS_SLOT_W-1:0]  out_slot;
  logic [PTS_RANGE_W-1:0] out_distance;
  logic [PTS_INTEN_W-1:0] out_intensity;
  logic                   out_last;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  pts_reg_t               cfg_index = PTS_REG_ENABLE;
  logic [PTS_RANGE_W-1:0] cfg_data = '0;
  int                     fails;
  int                     pending;
  int                     quiet = 0;
  int                     idle_pct = 0;

  localparam int QUIET_LIMIT = 5000;

  always #1 clk = ~clk;

  proximity_to_range_scan_top DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_front(frame[0]), .in_front_right(frame[1]), .in_right(frame[2]),
    .in_rear_right(frame[3]), .in_rear(frame[4]), .in_rear_left(frame[5]),
    .in_left(frame[6]), .in_front_left(frame[7]),
    .out_valid(out_valid), .out_kind(out_kind), .out_slot(out_slot),
    .out_distance(out_distance), .out_intensity(out_intensity), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  scan_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .frame(frame),
    .out_valid(out_valid), .out_kind(out_kind), .out_slot(out_slot),
    .out_distance(out_distance), .out_intensity(out_intensity), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .fails(fails), .pending(pending)
  );

  // End the run when no beat moves for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Send one frame; start stays high for a following frame
  task automatic send_frame(logic [7:0][9:0] f);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    frame <= f;
    do @(posedge clk); while (busy);
  endtask

  // Drain the block, then write one register
  task automatic write_reg(pts_reg_t idx, logic [15:0] val);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly uniform, with zero, the root/linear seam and the ends
  function automatic logic [9:0] pick_reading();
    case ($urandom_range(0, 9))
      0: return 10'd0;
      1: return 10'($urandom_range(945, 956));
      2: return 10'd1023;
      3: return 10'($urandom_range(1, 4));
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic random_frames(int n);
    logic [7:0][9:0] f;
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 8; i++) f[i] = pick_reading();
      send_frame(f);
    end
  endtask

  initial begin
    logic [7:0][9:0] f;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames at reset settings
    send_frame('0);
    send_frame({8{10'd1023}});
    send_frame({8{10'd1}});
    send_frame({8{10'd950}});
    send_frame({8{10'd951}});
    send_frame({8{10'h2AA}});
    send_frame({8{10'h155}});
    for (int i = 0; i < 8; i++) begin
      f = '0;
      f[i] = 10'd500;
      send_frame(f);
    end
    send_frame({10'd7, 10'd900, 10'd0, 10'd3, 10'd1023, 10'd40, 10'd951, 10'd2});

    // No idling
    random_frames(70);

    // Widest window and radius: ray sums saturate
    write_reg(PTS_REG_MIN_RANGE, 16'd0);
    write_reg(PTS_REG_MAX_RANGE, 16'hFFFF);
    write_reg(PTS_REG_BODY_RADIUS, 16'hFFFF);
    send_frame('0);
    send_frame({8{10'd1}});
    send_frame({8{10'd1023}});
    idle_pct = 62;
    random_frames(70);

    // Minimum above maximum, no radius
    write_reg(PTS_REG_MIN_RANGE, 16'hFFFF);
    write_reg(PTS_REG_MAX_RANGE, 16'd0);
    write_reg(PTS_REG_BODY_RADIUS, 16'd0);
    idle_pct = 0;
    random_frames(40);

    // Disabled: frames yield nothing
    write_reg(PTS_REG_ENABLE, 16'd0);
    random_frames(15);
    write_reg(PTS_REG_ENABLE, 16'd1);

    // Random window inside the useful span
    write_reg(PTS_REG_MIN_RANGE, 16'($urandom_range(0, 3000)));
    write_reg(PTS_REG_MAX_RANGE, 16'($urandom_range(2000, 20000)));
    write_reg(PTS_REG_BODY_RADIUS, 16'($urandom_range(0, 5000)));
    idle_pct = 8;
    random_frames(80);

    // Back to defaults
    write_reg(PTS_REG_MIN_RANGE, PTS_RST_MIN);
    write_reg(PTS_REG_MAX_RANGE, PTS_RST_MAX);
    write_reg(PTS_REG_BODY_RADIUS, PTS_RST_RADIUS);
    idle_pct = 62;
    random_frames(70);
    idle_pct = 0;
    random_frames(70);

    // Drain and give the verdict
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fails == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/pts_pkg.sv
rtl/pts_lane.sv
rtl/pts_conv.sv
rtl/proximity_to_range_scan_top.sv
rtl/pts_chk.sv
bench/scan_checker.sv
bench/tb_proximity_to_range_scan_top.sv
